// ----- design/ast_pkg.sv -----
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants for the assembly source tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

    // Identifier buffer size in characters and the index width into it.
    localparam int IDENT_CHARS = 8;
    localparam int IDENT_IDX_W = 3;

    // Width of the saturating number accumulator.
    localparam int NUMBER_BITS = 31;
    localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

    // Depth of the queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // The word "repeat", first character in the lowest byte.
    localparam logic [63:0] WORD_REPEAT = 64'h0000_7461_6570_6572;

    // Character codes that the scanner treats specially.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] COMMENT_CHAR_RESET = 8'h3B;

    typedef enum logic [2:0] {
        TK_ENDLINE = 3'd0,
        TK_IDENT   = 3'd1,
        TK_NUMBER  = 3'd2,
        TK_REPEAT  = 3'd3,
        TK_CHAR    = 3'd4,
        TK_EOF     = 3'd5,
        TK_ERROR   = 3'd6
    } token_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        token_kind_t                token_kind;
        logic [7:0]                 char_code;
        logic [63:0]                ident_text;
        logic [3:0]                 ident_length;
        logic                       ident_truncated;
        logic [NUMBER_BITS-1:0]     number_value;
        logic                       number_overflow;
        logic                       last_of_run;
    } tok_item_t;

    // One queue entry holds every token one source item causes. A second
    // token is never an identifier or number, so only its kind and code travel.
    typedef struct packed {
        tok_item_t   first;
        logic        has_second;
        token_kind_t second_kind;
        logic [7:0]  second_char;
    } ast_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- design/assembly_source_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_core
// Byte-stream lexer for assembly source text with a decoupled output stage.
// ----------------------------------------------------------------------------
// The block takes one source byte item per clock cycle and keeps taking them
// as long as its four-entry token queue has room; the scanner updates its
// mode, identifier buffer and decimal accumulator in the cycle an item is
// accepted. While tok_stall is low the output stage delivers one token per
// cycle; an item that causes two tokens (a pending identifier or number
// followed by a delimiter, or a pending token followed by EOF) uses it once
// per token, so one item per cycle holds only while the output is unstalled
// and most items cause at most one token. Tokens pass the queue and then the
// output register. Spaces, tabs and bytes inside a comment cause
// no token. After an error token the block keeps accepting items but is
// silent until reset; after EOF only further end-of-input items give tokens.
// The comment start byte is written through cfg_write and cfg_data and
// resets to a semicolon; it should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_core
    import ast_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       src_valid,
    output logic       src_stall,
    input  src_item_t  src_item,
    output logic       tok_valid,
    input  logic       tok_stall,
    output tok_item_t  tok_item
);

    // Queue interface between the scanner and the output stage.
    logic          q_push;
    logic          q_pop;
    ast_entry_t    q_data;
    ast_entry_t    q_head;
    queue_status_t q_status;

    // The scanner classifies each byte and pushes the tokens it causes.
    ast_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_item  (src_item),
        .src_stall (src_stall),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    // The queue lets the scanner run ahead while the output is stalled.
    ast_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // The output stage splits each entry into one or two token items.
    ast_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule

// ----- design/ast_front.sv -----
// ----------------------------------------------------------------------------
// ast_front
// Scanner: accepts source items, tracks the lexer mode and builds the tokens.
// ----------------------------------------------------------------------------
module ast_front
    import ast_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [7:0]    cfg_data,
    input  logic          src_valid,
    input  src_item_t     src_item,
    output logic          src_stall,
    input  queue_status_t q_status,
    output logic          q_push,
    output ast_entry_t    q_data
);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_IDENT   = 3'd1,
        M_DECIMAL = 3'd2,
        M_ZERO    = 3'd3,
        M_CR      = 3'd4,
        M_COMMENT = 3'd5,
        M_ERROR   = 3'd6,
        M_DONE    = 3'd7
    } scan_mode_t;

    scan_mode_t             mode_reg, mode_next;
    logic [63:0]            ibuf_reg, ibuf_next;
    logic [3:0]             icnt_reg, icnt_next;
    logic                   iovf_reg, iovf_next;
    logic [NUMBER_BITS-1:0] nacc_reg, nacc_next;
    logic                   nsat_reg, nsat_next;
    logic [7:0]             comment_reg;

    logic [7:0]             b;
    logic                   accept;
    logic                   is_alpha, is_num;

    logic                   idle_emit;
    token_kind_t            idle_kind;
    scan_mode_t             idle_mode;
    logic                   ld_ident, ld_zero, ld_digit;

    logic                   pend_valid;
    tok_item_t              pend_tok;
    logic [NUMBER_BITS+3:0] prod;

    logic                   do_pend, do_idle, fixed_emit, sm_valid;
    token_kind_t            fixed_kind, sm_kind;
    logic [7:0]             sm_char;

    assign b        = src_item.in_byte;
    assign accept   = src_valid && !q_status.full;
    assign src_stall = q_status.full;
    assign is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    assign is_num   = (b >= CH_ZERO && b <= 8'h39);

    // Digit accumulate: acc * 10 + d, checked against the saturation limit.
    assign prod = ({4'b0, nacc_reg} << 3) + ({4'b0, nacc_reg} << 1)
                + {(NUMBER_BITS)'(0), b[3:0] - CH_ZERO[3:0]};

    // What a byte does when no token is in progress.
    always_comb
    begin
        idle_emit = 1'b0;
        idle_kind = TK_CHAR;
        idle_mode = M_IDLE;
        ld_ident  = 1'b0;
        ld_zero   = 1'b0;
        ld_digit  = 1'b0;
        priority if (b == CH_SPACE || b == CH_TAB)
        begin
            idle_mode = M_IDLE;
        end
        else if (b == CH_LF)
        begin
            idle_emit = 1'b1;
            idle_kind = TK_ENDLINE;
        end
        else if (b == CH_CR)
        begin
            idle_emit = 1'b1;
            idle_kind = TK_ENDLINE;
            idle_mode = M_CR;
        end
        else if (is_alpha)
        begin
            ld_ident  = 1'b1;
            idle_mode = M_IDENT;
        end
        else if (b == CH_ZERO)
        begin
            ld_zero   = 1'b1;
            idle_mode = M_ZERO;
        end
        else if (is_num)
        begin
            ld_digit  = 1'b1;
            idle_mode = M_DECIMAL;
        end
        else if (b == comment_reg)
        begin
            idle_mode = M_COMMENT;
        end
        else
        begin
            idle_emit = 1'b1;
            idle_kind = TK_CHAR;
        end
    end

    // The token in progress, as it would be emitted now.
    always_comb
    begin
        pend_tok   = '0;
        pend_valid = 1'b0;
        unique case (mode_reg)
            M_IDENT:
            begin
                pend_valid = 1'b1;
                if (!iovf_reg && icnt_reg == 4'd6 && ibuf_reg == WORD_REPEAT)
                begin
                    pend_tok.token_kind = TK_REPEAT;
                end
                else
                begin
                    pend_tok.token_kind      = TK_IDENT;
                    pend_tok.ident_text      = ibuf_reg;
                    pend_tok.ident_length    = icnt_reg;
                    pend_tok.ident_truncated = iovf_reg;
                end
            end
            M_DECIMAL:
            begin
                pend_valid               = 1'b1;
                pend_tok.token_kind      = TK_NUMBER;
                pend_tok.number_value    = nacc_reg;
                pend_tok.number_overflow = nsat_reg;
            end
            M_ZERO:
            begin
                pend_valid          = 1'b1;
                pend_tok.token_kind = TK_NUMBER;
            end
            default:
            begin
                pend_valid = 1'b0;
            end
        endcase
    end

    // Mode transitions and token state update for one accepted item.
    always_comb
    begin
        mode_next  = mode_reg;
        ibuf_next  = ibuf_reg;
        icnt_next  = icnt_reg;
        iovf_next  = iovf_reg;
        nacc_next  = nacc_reg;
        nsat_next  = nsat_reg;
        do_pend    = 1'b0;
        do_idle    = 1'b0;
        fixed_emit = 1'b0;
        fixed_kind = TK_ENDLINE;

        if (mode_reg == M_ERROR)
        begin
            mode_next = M_ERROR;
        end
        else if (src_item.end_of_input)
        begin
            do_pend    = pend_valid;
            fixed_emit = 1'b1;
            fixed_kind = TK_EOF;
            mode_next  = M_DONE;
        end
        else
        begin
            unique case (mode_reg)
                M_DONE:
                begin
                    mode_next = M_DONE;
                end
                M_COMMENT:
                begin
                    if (b == CH_LF)
                    begin
                        fixed_emit = 1'b1;
                        mode_next  = M_IDLE;
                    end
                    else if (b == CH_CR)
                    begin
                        fixed_emit = 1'b1;
                        mode_next  = M_CR;
                    end
                end
                M_CR:
                begin
                    mode_next = M_IDLE;
                    do_idle   = (b != CH_LF);
                end
                M_IDENT:
                begin
                    if (is_alpha || is_num)
                    begin
                        if (icnt_reg < 4'(IDENT_CHARS))
                        begin
                            ibuf_next[8*icnt_reg[IDENT_IDX_W-1:0] +: 8] = b;
                            icnt_next = icnt_reg + 4'd1;
                        end
                        else
                        begin
                            iovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        do_pend = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_DECIMAL:
                begin
                    if (is_num)
                    begin
                        if (nsat_reg || prod > {4'b0, NUM_MAX})
                        begin
                            nacc_next = NUM_MAX;
                            nsat_next = 1'b1;
                        end
                        else
                        begin
                            nacc_next = prod[NUMBER_BITS-1:0];
                        end
                    end
                    else
                    begin
                        do_pend = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_ZERO:
                begin
                    if (is_num)
                    begin
                        fixed_emit = 1'b1;
                        fixed_kind = TK_ERROR;
                        mode_next  = M_ERROR;
                    end
                    else
                    begin
                        do_pend = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase
        end

        // Emitting the token in progress, or failing with an error, clears it.
        if (do_pend || fixed_kind == TK_ERROR)
        begin
            ibuf_next = '0;
            icnt_next = '0;
            iovf_next = 1'b0;
            nacc_next = '0;
            nsat_next = 1'b0;
        end

        if (do_idle)
        begin
            mode_next = idle_mode;
            if (ld_ident || ld_zero || ld_digit)
            begin
                ibuf_next = '0;
                icnt_next = '0;
                iovf_next = 1'b0;
                nacc_next = '0;
                nsat_next = 1'b0;
            end
            if (ld_ident)
            begin
                ibuf_next = {56'b0, b};
                icnt_next = 4'd1;
            end
            if (ld_digit)
            begin
                nacc_next = {(NUMBER_BITS-4)'(0), b[3:0] - CH_ZERO[3:0]};
            end
        end
    end

    // The token that is not an identifier or number, if any.
    assign sm_valid = fixed_emit || (do_idle && idle_emit);
    assign sm_kind  = fixed_emit ? fixed_kind : idle_kind;
    assign sm_char  = (!fixed_emit && idle_kind == TK_CHAR) ? b : 8'h00;

    always_comb
    begin
        q_data = '0;
        if (do_pend)
        begin
            q_data.first       = pend_tok;
            q_data.has_second  = sm_valid;
            q_data.second_kind = sm_kind;
            q_data.second_char = sm_char;
        end
        else
        begin
            q_data.first.token_kind = sm_kind;
            q_data.first.char_code  = sm_char;
            q_data.second_kind      = TK_ENDLINE;
        end
    end

    assign q_push = accept && (do_pend || sm_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            ibuf_reg    <= '0;
            icnt_reg    <= '0;
            iovf_reg    <= 1'b0;
            nacc_reg    <= '0;
            nsat_reg    <= 1'b0;
            comment_reg <= COMMENT_CHAR_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                comment_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg <= mode_next;
                ibuf_reg <= ibuf_next;
                icnt_reg <= icnt_next;
                iovf_reg <= iovf_next;
                nacc_reg <= nacc_next;
                nsat_reg <= nsat_next;
            end
        end
    end

endmodule

// ----- design/ast_fifo.sv -----
// ----------------------------------------------------------------------------
// ast_fifo
// Short queue of token entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
module ast_fifo
    import ast_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ast_entry_t    push_data,
    input  logic          pop,
    output ast_entry_t    head,
    output queue_status_t status
);

    ast_entry_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/ast_back.sv -----
// ----------------------------------------------------------------------------
// ast_back
// Output stage: delivers the tokens of each queue entry one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ast_back
    import ast_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ast_entry_t    q_head,
    input  queue_status_t q_status,
    output logic          q_pop,
    output logic          tok_valid,
    input  logic          tok_stall,
    output tok_item_t     tok_item
);

    typedef enum logic {
        PH_FIRST  = 1'b0,
        PH_SECOND = 1'b1
    } phase_t;

    phase_t    phase_reg, phase_next;
    logic      valid_reg, valid_next;
    tok_item_t item_reg, item_next;
    logic      slot_free, load;

    assign slot_free = !valid_reg || !tok_stall;
    assign load      = slot_free && !q_status.empty;

    always_comb
    begin
        phase_next = phase_reg;
        item_next  = item_reg;
        valid_next = valid_reg && !slot_free;
        q_pop      = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            unique case (phase_reg)
                PH_FIRST:
                begin
                    item_next             = q_head.first;
                    item_next.last_of_run = !q_head.has_second;
                    q_pop                 = !q_head.has_second;
                    phase_next            = q_head.has_second ? PH_SECOND : PH_FIRST;
                end
                PH_SECOND:
                begin
                    item_next             = '0;
                    item_next.token_kind  = q_head.second_kind;
                    item_next.char_code   = q_head.second_char;
                    item_next.last_of_run = 1'b1;
                    q_pop                 = 1'b1;
                    phase_next            = PH_FIRST;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            item_reg  <= item_next;
        end
    end

    assign tok_valid = valid_reg;
    assign tok_item  = item_reg;

endmodule

// ----- design/ast_checker.sv -----
// ----------------------------------------------------------------------------
// ast_checker
// Port-level checks on the token stream of the tokenizer.
// ----------------------------------------------------------------------------
module ast_checker
    import ast_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      tok_valid,
    input logic      tok_stall,
    input tok_item_t tok_item
);

    // A stalled token item holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
    else $error("stalled token item changed");

    // Identifier fields are zero on every other kind of token.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind != TK_IDENT |->
            tok_item.ident_text == '0 && tok_item.ident_length == '0
            && !tok_item.ident_truncated)
    else $error("identifier fields set on a non-identifier token");

    // Only single-character tokens carry a character code.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind != TK_CHAR |-> tok_item.char_code == 8'h00)
    else $error("character code set on a non-character token");

    // A saturated number always reads as the maximum value.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.number_overflow |->
            tok_item.number_value == NUM_MAX && tok_item.token_kind == TK_NUMBER)
    else $error("overflowed number is not at its maximum");

    // A truncated identifier fills the whole buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.ident_truncated |->
            tok_item.ident_length == 4'(IDENT_CHARS))
    else $error("truncated identifier with a partly filled buffer");

endmodule

bind assembly_source_tokenizer_core ast_checker u_ast_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
);
